// ===== hw/rtl/snd_pkg.sv =====
`default_nettype none

package snd_pkg;

    localparam int OPERAND_W     = 16;
    localparam int QUOT_W        = 17;
    localparam int MAX_WIDTH_DEF = 16;

    // width_select codes
    localparam logic [1:0] WSEL_4   = 2'd0;
    localparam logic [1:0] WSEL_8   = 2'd1;
    localparam logic [1:0] WSEL_16  = 2'd2;
    localparam logic [1:0] WSEL_MAX = 2'd3;

    typedef struct packed {
        logic [OPERAND_W-1:0] dividend_bits;
        logic [OPERAND_W-1:0] divisor_bits;
    } snd_in_t;

    typedef struct packed {
        logic signed [QUOT_W-1:0] quotient;
        logic                     divide_by_zero;
    } snd_out_t;

    typedef struct packed {
        logic negate;
        logic div_zero;
    } snd_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/signed_nonrestoring_divider_unit.sv =====
// Signed divider, pipelined, one quotient bit per stage.
// Input channel s_valid/s_ready/s_data carries a word with dividend_bits and
// divisor_bits; the low width bits of each are two's complement operands.
// Output channel m_valid/m_ready/m_data returns the quotient truncated toward
// zero (17 bits, not wrapped) and a divide_by_zero flag (quotient then 0).
// cfg_valid/cfg_data writes width_select (0: 4, 1: 8, 2: 16 bits, 3: MAX_WIDTH);
// cfg_ready is always high. Write it only while the pipeline is empty.
// Stages: an operand stage, one non-restoring iteration per quotient bit, and
// a sign-fix output register. Throughput is one word per cycle while m_ready
// is high; every stage holds one word.
// Each stage has its own valid bit and a ready term that looks only at the
// next stage, so a stalled receiver freezes only the full tail of the pipe;
// empty stages ahead still fill and the input keeps accepting until the
// pipe is full. Nothing is dropped or repeated under stall.
// Reset clears all valid bits and sets width_select to 16 bits.
`default_nettype none

module signed_nonrestoring_divider_unit #(
    parameter int MAX_WIDTH = snd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire snd_pkg::snd_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output snd_pkg::snd_out_t      m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_data
);
    import snd_pkg::*;

    localparam int N  = MAX_WIDTH;
    localparam int WW = $clog2(N + 1);
    localparam int W8  = (8 > N) ? N : 8;
    localparam int W16 = (16 > N) ? N : 16;

    logic [1:0]    width_select_reg;
    logic [WW-1:0] op_w;
    logic [N-1:0]  mask;
    logic [N-1:0]  sign_mask;
    logic [N-1:0]  a_low;
    logic [N-1:0]  b_low;
    logic          sa;
    logic          sb;
    logic [N-1:0]  mag_a;
    logic [N-1:0]  mag_b;

    // stage index k holds the word after k iterations
    logic          v_s     [0:N];
    logic          rdy_s   [0:N];
    logic [N+1:0]  rem_s   [0:N];
    logic [N-1:0]  aq_s    [0:N];
    logic [N-1:0]  div_s   [0:N];
    snd_flags_t    flags_s [0:N];

    logic          in_valid_reg;
    logic [N-1:0]  in_a_reg;
    logic [N-1:0]  in_b_reg;
    snd_flags_t    in_flags_reg;

    logic          out_valid_reg;
    snd_out_t      out_reg;
    snd_out_t      out_next;
    logic [QUOT_W-1:0] q_mag;
    logic          out_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_select_reg <= WSEL_16;
        end else if (cfg_valid) begin
            width_select_reg <= cfg_data;
        end
    end

    always_comb begin
        unique case (width_select_reg)
            WSEL_4:   op_w = WW'(4);
            WSEL_8:   op_w = WW'(W8);
            WSEL_16:  op_w = WW'(W16);
            WSEL_MAX: op_w = WW'(N);
            default:  op_w = WW'(N);
        endcase
        mask      = ~({N{1'b1}} << op_w);
        sign_mask = mask ^ (mask >> 1);
        a_low     = s_data.dividend_bits[N-1:0] & mask;
        b_low     = s_data.divisor_bits[N-1:0] & mask;
        sa        = |(a_low & sign_mask);
        sb        = |(b_low & sign_mask);
        // most negative value maps to 2^(w-1) under the mask
        mag_a     = sa ? ((~a_low + 1'b1) & mask) : a_low;
        mag_b     = sb ? ((~b_low + 1'b1) & mask) : b_low;
    end

    // operand stage
    assign s_ready = !in_valid_reg || rdy_s[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_a_reg              <= mag_a;
            in_b_reg              <= mag_b;
            in_flags_reg.negate   <= sa ^ sb;
            in_flags_reg.div_zero <= (b_low == '0);
        end
    end

    assign v_s[0]     = in_valid_reg;
    assign rem_s[0]   = '0;
    assign aq_s[0]    = in_a_reg;
    assign div_s[0]   = in_b_reg;
    assign flags_s[0] = in_flags_reg;

    for (genvar k = 1; k <= N; k++) begin : g_iter
        snd_step #(
            .N(N)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (v_s[k-1]),
            .up_ready (rdy_s[k-1]),
            .up_rem   (rem_s[k-1]),
            .up_aq    (aq_s[k-1]),
            .up_div   (div_s[k-1]),
            .up_flags (flags_s[k-1]),
            .dn_valid (v_s[k]),
            .dn_ready (rdy_s[k]),
            .dn_rem   (rem_s[k]),
            .dn_aq    (aq_s[k]),
            .dn_div   (div_s[k]),
            .dn_flags (flags_s[k])
        );
    end

    // sign fix and output register; the remainder after the last step is unused
    assign out_ready = !out_valid_reg || m_ready;
    assign rdy_s[N]  = out_ready;

    always_comb begin
        q_mag = {{(QUOT_W-N){1'b0}}, aq_s[N]};
        out_next.divide_by_zero = flags_s[N].div_zero;
        priority if (flags_s[N].div_zero) begin
            out_next.quotient = '0;
        end else if (flags_s[N].negate) begin
            out_next.quotient = $signed(~q_mag + 1'b1);
        end else begin
            out_next.quotient = $signed(q_mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= v_s[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && v_s[N]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/snd_step.sv =====
`default_nettype none

module snd_step #(
    parameter int N = snd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire logic [N+1:0]        up_rem,
    input  wire logic [N-1:0]        up_aq,
    input  wire logic [N-1:0]        up_div,
    input  wire snd_pkg::snd_flags_t up_flags,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output logic [N+1:0]             dn_rem,
    output logic [N-1:0]             dn_aq,
    output logic [N-1:0]             dn_div,
    output snd_pkg::snd_flags_t      dn_flags
);
    import snd_pkg::*;

    logic             valid_reg;
    logic [N+1:0]     rem_reg;
    logic [N-1:0]     aq_reg;
    logic [N-1:0]     div_reg;
    snd_flags_t       flags_reg;
    logic [N+1:0]     rem_shift;
    logic [N+1:0]     div_ext;
    logic [N+1:0]     rem_next;
    logic [N-1:0]     aq_next;

    // one non-restoring step: add the divisor back on a negative remainder, else subtract it
    always_comb begin
        rem_shift = {up_rem[N:0], up_aq[N-1]};
        div_ext   = {2'b00, up_div};
        if (up_rem[N+1]) begin
            rem_next = rem_shift + div_ext;
        end else begin
            rem_next = rem_shift - div_ext;
        end
        aq_next = {up_aq[N-2:0], ~rem_next[N+1]};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            rem_reg   <= rem_next;
            aq_reg    <= aq_next;
            div_reg   <= up_div;
            flags_reg <= up_flags;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_aq    = aq_reg;
    assign dn_div   = div_reg;
    assign dn_flags = flags_reg;

endmodule

`default_nettype wire
